// ===== design/utv_pkg.sv =====
// utv_pkg: shared types and byte/code point constants for the UTF-8 text validator.
// No dependencies; imported by utf8_text_validator_unit.
package utv_pkg;

	// Progress through a possible leading EF BB BF mark
	typedef enum logic [1:0] {
		BOM_FIRST = 2'd0,
		BOM_EF    = 2'd1,
		BOM_EFBB  = 2'd2,
		BOM_PAST  = 2'd3
	} bom_state_t;

	// Lead byte ranges
	localparam logic [7:0] LEAD2_LO   = 8'hc2;
	localparam logic [7:0] LEAD2_HI   = 8'hdf;
	localparam logic [7:0] LEAD3_LO   = 8'he0;
	localparam logic [7:0] LEAD3_HI   = 8'hef;
	localparam logic [7:0] LEAD4_LO   = 8'hf0;
	localparam logic [7:0] LEAD4_HI   = 8'hf4;
	localparam logic [7:0] ASCII_HI   = 8'h7f;

	// Byte order mark and carriage return
	localparam logic [7:0] BOM_BYTE0  = 8'hef;
	localparam logic [7:0] BOM_BYTE1  = 8'hbb;
	localparam logic [7:0] BOM_BYTE2  = 8'hbf;
	localparam logic [7:0] CR_BYTE    = 8'h0d;

	// Code point limits
	localparam logic [20:0] CP_MIN2   = 21'h00080;
	localparam logic [20:0] CP_MIN3   = 21'h00800;
	localparam logic [20:0] CP_MIN4   = 21'h10000;
	localparam logic [20:0] CP_MAX    = 21'h10ffff;
	localparam logic [20:0] SURR_LO   = 21'h0d800;
	localparam logic [20:0] SURR_HI   = 21'h0dfff;

	// Sequence length classes (length minus one)
	localparam logic [1:0] CLS_ONE    = 2'd0;
	localparam logic [1:0] CLS_TWO    = 2'd1;
	localparam logic [1:0] CLS_THREE  = 2'd2;
	localparam logic [1:0] CLS_FOUR   = 2'd3;

endpackage

// ===== design/utf8_text_validator_unit.sv =====
// utf8_text_validator_unit: strict UTF-8 checker, one byte per transfer, with
// sticky no-error flag and whole-text verdict. Depends on utv_pkg.
//
// Channel   Direction  Handshake                 Payload
// in        to block   in_valid / in_ready       text_byte[7:0], last_byte
// out       from block out_valid / out_ready     no_error_yet, text_valid, text_end
// cfg       to block   cfg_write_en (no wait)    cfg_write_data -> canonical_mode
//
// One byte per cycle sustained while out_ready is high; each byte passes through
// the input register _s1, then the decode logic into result register _s2.
// in_ready follows out_ready combinationally through the two stages, so a full
// pipeline keeps moving as long as the sink takes results each cycle.
// Reset clears the text state and canonical_mode; the end of a text clears the
// text state only. The decoder state advances when a byte moves from _s1 to _s2.
module utf8_text_validator_unit
	import utv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       last_byte,
	// output channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       no_error_yet,
	output logic       text_valid,
	output logic       text_end,
	// configuration
	input  logic       cfg_write_en,
	input  logic       cfg_write_data
);

	// configuration register
	logic canonical_mode_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result stage
	logic valid_s2;
	logic no_error_s2;
	logic text_valid_s2;
	logic text_end_s2;

	// text state
	bom_state_t  bom_q, bom_d;
	logic        error_seen_q, error_seen_d;
	logic [1:0]  cont_left_q, cont_left_d;
	logic [20:0] cp_acc_q, cp_acc_d;
	logic [1:0]  len_class_q, len_class_d;

	logic adv_s2;   // byte moves from _s1 into result register
	logic bad;
	logic bom_hit;  // third byte of leading mark seen
	logic [20:0] cp_next;
	logic [20:0] cp_min;
	logic        cp_ok;

	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canonical_mode_q <= 1'b0;
		end else if (cfg_write_en) begin
			canonical_mode_q <= cfg_write_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	// leading mark tracker: next state
	always_comb begin
		bom_d = bom_q;
		unique case (bom_q)
			BOM_FIRST: bom_d = (byte_s1 == BOM_BYTE0) ? BOM_EF : BOM_PAST;
			BOM_EF:    bom_d = (byte_s1 == BOM_BYTE1) ? BOM_EFBB : BOM_PAST;
			BOM_EFBB:  bom_d = BOM_PAST;
			BOM_PAST:  bom_d = BOM_PAST;
			default:   bom_d = BOM_PAST;
		endcase
	end

	// leading mark tracker: output
	always_comb begin
		bom_hit = 1'b0;
		unique case (bom_q)
			BOM_EFBB: bom_hit = (byte_s1 == BOM_BYTE2);
			default:  bom_hit = 1'b0;
		endcase
	end

	// code point completion check: minimum for its length, maximum and surrogate range
	assign cp_next = {cp_acc_q[14:0], byte_s1[5:0]};

	always_comb begin
		case (len_class_q)
			CLS_TWO:   cp_min = CP_MIN2;
			CLS_THREE: cp_min = CP_MIN3;
			default:   cp_min = CP_MIN4;
		endcase
	end

	assign cp_ok = (cp_next >= cp_min) && (cp_next <= CP_MAX) &&
		!((cp_next >= SURR_LO) && (cp_next <= SURR_HI));

	// byte decode
	always_comb begin
		bad         = canonical_mode_q && (bom_hit || byte_s1 == CR_BYTE);
		cont_left_d = cont_left_q;
		cp_acc_d    = cp_acc_q;
		len_class_d = len_class_q;

		if (cont_left_q != 2'd0) begin
			if (byte_s1[7:6] != 2'b10) begin
				bad         = 1'b1;
				cont_left_d = 2'd0;
			end else begin
				cp_acc_d    = cp_next;
				cont_left_d = cont_left_q - 2'd1;
				// final continuation: whole code point must be in range
				if (cont_left_q == 2'd1 && !cp_ok) begin
					bad = 1'b1;
				end
			end
		end else if (byte_s1 <= ASCII_HI) begin
			// ASCII, nothing to track
		end else if (byte_s1 >= LEAD2_LO && byte_s1 <= LEAD2_HI) begin
			cont_left_d = 2'd1;
			cp_acc_d    = {16'd0, byte_s1[4:0]};
			len_class_d = CLS_TWO;
		end else if (byte_s1 >= LEAD3_LO && byte_s1 <= LEAD3_HI) begin
			cont_left_d = 2'd2;
			cp_acc_d    = {17'd0, byte_s1[3:0]};
			len_class_d = CLS_THREE;
		end else if (byte_s1 >= LEAD4_LO && byte_s1 <= LEAD4_HI) begin
			cont_left_d = 2'd3;
			cp_acc_d    = {18'd0, byte_s1[2:0]};
			len_class_d = CLS_FOUR;
		end else begin
			// stray continuation, C0/C1, F5..FF
			bad = 1'b1;
		end

		// text cut off mid-sequence
		if (last_s1 && cont_left_d != 2'd0) begin
			bad = 1'b1;
		end
		if (bad) begin
			cont_left_d = 2'd0;
		end
		error_seen_d = error_seen_q || bad;
	end

	// text state; cleared after the last byte of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bom_q        <= BOM_FIRST;
			error_seen_q <= 1'b0;
			cont_left_q  <= 2'd0;
			cp_acc_q     <= 21'd0;
			len_class_q  <= CLS_ONE;
		end else if (adv_s2) begin
			if (last_s1) begin
				bom_q        <= BOM_FIRST;
				error_seen_q <= 1'b0;
				cont_left_q  <= 2'd0;
				cp_acc_q     <= 21'd0;
				len_class_q  <= CLS_ONE;
			end else begin
				bom_q        <= bom_d;
				error_seen_q <= error_seen_d;
				cont_left_q  <= cont_left_d;
				cp_acc_q     <= cp_acc_d;
				len_class_q  <= len_class_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			no_error_s2   <= !error_seen_d;
			text_valid_s2 <= last_s1 && !error_seen_d;
			text_end_s2   <= last_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign no_error_yet = no_error_s2;
	assign text_valid   = text_valid_s2;
	assign text_end     = text_end_s2;

	// a pending sequence always has a multi-byte length class
	a_cont_class: assert property (@(posedge clk) disable iff (!arst_n)
		cont_left_q != 2'd0 |-> len_class_q != CLS_ONE)
		else $error("pending continuations without a multi-byte class");

	// the end of a text returns the decoder to its start state
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && last_s1 |=> !error_seen_q && cont_left_q == 2'd0 && bom_q == BOM_FIRST)
		else $error("text state not cleared after last byte");

	// error flag is sticky within a text
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && !last_s1 && error_seen_q |=> error_seen_q)
		else $error("error flag dropped mid-text");

	// a valid verdict only on the last byte of an error-free text
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && text_valid_s2 |-> text_end_s2 && no_error_s2)
		else $error("verdict outside text end or with error");

endmodule
